/* rtl/asv_pkg.sv */
// ----------------------------------------------------------------------------
// asv_pkg
// Shared types, tag codes and character class functions for the ASN.1
// string type validator.
// ----------------------------------------------------------------------------
package asv_pkg;

  // universal tags of the supported string types
  localparam logic [7:0] TAG_UTF8      = 8'd12;
  localparam logic [7:0] TAG_NUMERIC   = 8'd18;
  localparam logic [7:0] TAG_PRINTABLE = 8'd19;
  localparam logic [7:0] TAG_T61       = 8'd20;
  localparam logic [7:0] TAG_IA5       = 8'd22;
  localparam logic [7:0] TAG_BMP       = 8'd30;

  // utf-8 limits
  localparam logic [20:0] CP_MAX        = 21'h10ffff;
  localparam logic [20:0] CP_SURR_LO    = 21'h00d800;
  localparam logic [20:0] CP_SURR_HI    = 21'h00dfff;
  localparam logic [20:0] CP_MIN_2BYTE  = 21'h000080;
  localparam logic [20:0] CP_MIN_3BYTE  = 21'h000800;
  localparam logic [20:0] CP_MIN_4BYTE  = 21'h010000;

  // bmp limits
  localparam logic [15:0] BMP_SURR_LO   = 16'hd800;
  localparam logic [15:0] BMP_SURR_HI   = 16'hdfff;
  localparam logic [15:0] BMP_NONCH_LO  = 16'hfdd0;
  localparam logic [15:0] BMP_NONCH_HI  = 16'hfdef;
  localparam logic [15:0] BMP_FFFE      = 16'hfffe;

  typedef enum logic [2:0] {
    KIND_REJECT    = 3'd0,
    KIND_UTF8      = 3'd1,
    KIND_BMP       = 3'd2,
    KIND_NUMERIC   = 3'd3,
    KIND_PRINTABLE = 3'd4,
    KIND_IA5       = 3'd5,
    KIND_T61       = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] type_tag;
    logic [7:0] byte_value;
    logic       empty_string;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic res_valid;
    logic res_ok;
  } chk_res_t;

  function automatic kind_t kind_of_tag(input logic [7:0] tag);
    kind_t k;
    case (tag)
      TAG_UTF8:      k = KIND_UTF8;
      TAG_BMP:       k = KIND_BMP;
      TAG_NUMERIC:   k = KIND_NUMERIC;
      TAG_PRINTABLE: k = KIND_PRINTABLE;
      TAG_IA5:       k = KIND_IA5;
      TAG_T61:       k = KIND_T61;
      default:       k = KIND_REJECT;
    endcase
    return k;
  endfunction

  function automatic logic is_numeric(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], 8'h20});
  endfunction

  function automatic logic is_printable(input logic [7:0] b);
    return is_numeric(b) ||
           (b inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h27:8'h2f],
                      8'h3a, 8'h3d, 8'h3f, 8'h26});
  endfunction

endpackage

/* rtl/asv_if.sv */
// ----------------------------------------------------------------------------
// asv_if
// Valid/ready stream interfaces for the string bytes and the verdicts.
// ----------------------------------------------------------------------------
interface asv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] type_tag;
  logic [7:0] byte_value;
  logic       empty_string;
  logic       last;

  modport source (output valid, type_tag, byte_value, empty_string, last,
                  input ready);
  modport sink   (input valid, type_tag, byte_value, empty_string, last,
                  output ready);
endinterface

interface asv_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, valid_res, input ready);
  modport sink   (input valid, valid_res, output ready);
endinterface

/* rtl/asv_checker.sv */
// ----------------------------------------------------------------------------
// asv_checker
// Per-string check state and the combinational byte check for all string
// kinds; gives a verdict on the last item of a string.
// ----------------------------------------------------------------------------
module asv_checker
  import asv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  in_item_t item,
  output chk_res_t res
);

  logic        in_string_r, in_string_nxt;
  kind_t       kind_r, kind_nxt;
  logic        failed_r, failed_nxt;
  logic [1:0]  cont_left_r, cont_left_nxt;
  logic [1:0]  seq_len_r, seq_len_nxt;
  logic [20:0] code_point_r, code_point_nxt;
  logic [7:0]  unit_hi_r, unit_hi_nxt;
  logic        odd_r, odd_nxt;

  // values at the start of this item
  kind_t       kind_s;
  logic        failed_s;
  logic [1:0]  cont_s;
  logic [1:0]  seq_s;
  logic [20:0] cp_s;
  logic [7:0]  hi_s;
  logic        odd_s;

  logic [7:0]  b;
  logic        byte_ok;
  logic [20:0] cp_cont;
  logic [1:0]  cont_dec;
  logic [20:0] cp_least;
  logic [15:0] unit;

  assign b        = item.byte_value;
  assign cp_cont  = {cp_s[14:0], b[5:0]};
  assign cont_dec = cont_s - 2'd1;
  assign unit     = {hi_s, b};

  always_comb begin
    case (seq_s)
      2'd1:    cp_least = CP_MIN_2BYTE;
      2'd2:    cp_least = CP_MIN_3BYTE;
      default: cp_least = CP_MIN_4BYTE;
    endcase
  end

  always_comb begin
    if (!in_string_r) begin
      kind_s   = kind_of_tag(item.type_tag);
      failed_s = (kind_of_tag(item.type_tag) == KIND_REJECT);
      cont_s   = 2'd0;
      seq_s    = 2'd0;
      cp_s     = '0;
      hi_s     = '0;
      odd_s    = 1'b0;
    end else begin
      kind_s   = kind_r;
      failed_s = failed_r;
      cont_s   = cont_left_r;
      seq_s    = seq_len_r;
      cp_s     = code_point_r;
      hi_s     = unit_hi_r;
      odd_s    = odd_r;
    end

    kind_nxt       = kind_s;
    cont_left_nxt  = cont_s;
    seq_len_nxt    = seq_s;
    code_point_nxt = cp_s;
    unit_hi_nxt    = hi_s;
    odd_nxt        = odd_s;
    byte_ok        = 1'b1;

    if (!item.empty_string && !failed_s) begin
      case (kind_s)
        KIND_UTF8: begin
          if (cont_s == 2'd0) begin
            if (b < 8'h80) begin
              byte_ok = 1'b1;
            end else if (b inside {[8'hc2:8'hdf]}) begin
              code_point_nxt = {16'd0, b[4:0]};
              cont_left_nxt  = 2'd1;
              seq_len_nxt    = 2'd1;
            end else if (b inside {[8'he0:8'hef]}) begin
              code_point_nxt = {17'd0, b[3:0]};
              cont_left_nxt  = 2'd2;
              seq_len_nxt    = 2'd2;
            end else if (b inside {[8'hf0:8'hf4]}) begin
              code_point_nxt = {18'd0, b[2:0]};
              cont_left_nxt  = 2'd3;
              seq_len_nxt    = 2'd3;
            end else begin
              byte_ok = 1'b0;
            end
          end else if (b[7:6] != 2'b10) begin
            byte_ok = 1'b0;
          end else begin
            code_point_nxt = cp_cont;
            cont_left_nxt  = cont_dec;
            if (cont_dec == 2'd0) begin
              byte_ok = !(cp_cont < cp_least || cp_cont > CP_MAX ||
                          (cp_cont >= CP_SURR_LO && cp_cont <= CP_SURR_HI));
            end
          end
        end
        KIND_BMP: begin
          if (!odd_s) begin
            unit_hi_nxt = b;
            odd_nxt     = 1'b1;
          end else begin
            odd_nxt = 1'b0;
            byte_ok = !(unit >= BMP_FFFE ||
                        (unit >= BMP_NONCH_LO && unit <= BMP_NONCH_HI) ||
                        (unit >= BMP_SURR_LO && unit <= BMP_SURR_HI));
          end
        end
        KIND_NUMERIC:   byte_ok = is_numeric(b);
        KIND_PRINTABLE: byte_ok = is_printable(b);
        KIND_IA5:       byte_ok = (b < 8'h80);
        KIND_T61:       byte_ok = 1'b1;
        default:        byte_ok = 1'b0;
      endcase
    end

    failed_nxt    = failed_s || !byte_ok;
    in_string_nxt = !item.last;

    res.res_valid = go && item.last;
    res.res_ok    = !failed_nxt && (cont_left_nxt == 2'd0) && !odd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_string_r  <= 1'b0;
      kind_r       <= KIND_REJECT;
      failed_r     <= 1'b0;
      cont_left_r  <= 2'd0;
      seq_len_r    <= 2'd0;
      code_point_r <= '0;
      unit_hi_r    <= '0;
      odd_r        <= 1'b0;
    end else if (go) begin
      in_string_r  <= in_string_nxt;
      kind_r       <= kind_nxt;
      failed_r     <= failed_nxt;
      cont_left_r  <= cont_left_nxt;
      seq_len_r    <= seq_len_nxt;
      code_point_r <= code_point_nxt;
      unit_hi_r    <= unit_hi_nxt;
      odd_r        <= odd_nxt;
    end
  end

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.last |=> !in_string_r)
    else $error("string still open after its last transfer");

  a_cont_utf8: assert property (@(posedge clk) disable iff (!rst_n)
    cont_left_r != 2'd0 |-> kind_r == KIND_UTF8)
    else $error("open utf-8 sequence outside a utf-8 string");

  a_odd_bmp: assert property (@(posedge clk) disable iff (!rst_n)
    odd_r |-> kind_r == KIND_BMP)
    else $error("pending bmp byte outside a bmp string");

  a_cont_le_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cont_left_r != 2'd0 |-> cont_left_r <= seq_len_r)
    else $error("continuations left exceed sequence length");

endmodule

/* rtl/asn1_string_type_validator_top.sv */
// ----------------------------------------------------------------------------
// asn1_string_type_validator_top
// Validates ASN.1 character strings fed one content byte per transfer and
// returns one verdict per string.
// ----------------------------------------------------------------------------
// The block takes one byte transfer every clock cycle, save for the hold
// named below. The byte that carries last is checked while it sits in the
// input register, and the verdict is loaded into the result register at the
// edge on which that byte is taken from the input register; the verdict
// transfer is offered from the result register.
// The rate is set by the check state of the current string, which is read
// and rewritten once per byte. A byte transfer is held back
// only while a finished verdict waits in the result register and the byte in
// the input register closes another string.
module asn1_string_type_validator_top
  import asv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  asv_in_if.sink           in_ch,
  asv_out_if.source        out_ch
);

  logic     s1_vld_r, s1_vld_nxt;
  in_item_t s1_item_r, s1_item_nxt;
  logic     out_vld_r, out_vld_nxt;
  logic     out_res_r, out_res_nxt;
  logic     go;
  logic     in_rdy;
  chk_res_t res;

  assign go     = s1_vld_r && (!s1_item_r.last || !out_vld_r || out_ch.ready);
  assign in_rdy = !s1_vld_r || go;

  assign in_ch.ready      = in_rdy;
  assign out_ch.valid     = out_vld_r;
  assign out_ch.valid_res = out_res_r;

  asv_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (s1_item_r),
    .res   (res)
  );

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    s1_item_nxt = s1_item_r;
    if (in_rdy) begin
      s1_vld_nxt              = in_ch.valid;
      s1_item_nxt.type_tag     = in_ch.type_tag;
      s1_item_nxt.byte_value   = in_ch.byte_value;
      s1_item_nxt.empty_string = in_ch.empty_string;
      s1_item_nxt.last         = in_ch.last;
    end

    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (res.res_valid) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res.res_ok;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the ASN.1 string type validator. Strings are fed one byte
// per transfer, and a local model of the per-type checks predicts each
// verdict. Each verdict is compared with the oldest prediction. Directed
// strings cover the rule edges. Random strings, mostly well-formed and
// sometimes broken, follow. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
  import asv_pkg::*;
();

  logic clk = 1'b0;
  logic rst_n;

  asv_in_if  in_ch ();
  asv_out_if out_ch ();

  asn1_string_type_validator_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  int  errors = 0;
  int  bytes_sent = 0;
  bit  in_steady = 1'b0;
  bit  out_steady = 1'b0;
  bit  verdicts_due[$];

  kind_t       cur_kind = KIND_REJECT;
  bit          in_str = 1'b0;
  bit          str_bad = 1'b0;
  bit          half_unit = 1'b0;
  logic [1:0]  cont_left = '0;
  logic [1:0]  seq_len = '0;
  logic [20:0] cp_acc = '0;
  logic [7:0]  unit_hi = '0;

  task automatic report_error(input string msg);
    errors++;
    $display("%0t ERROR: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // verdict prediction

  function automatic kind_t class_for_tag(input logic [7:0] tag);
    case (tag)
      TAG_UTF8:      return KIND_UTF8;
      TAG_BMP:       return KIND_BMP;
      TAG_NUMERIC:   return KIND_NUMERIC;
      TAG_PRINTABLE: return KIND_PRINTABLE;
      TAG_IA5:       return KIND_IA5;
      TAG_T61:       return KIND_T61;
      default:       return KIND_REJECT;
    endcase
  endfunction

  function automatic bit numeric_char(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || b == 8'h20;
  endfunction

  function automatic bit printable_char(input logic [7:0] b);
    return numeric_char(b) || (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
           (b >= 8'h27 && b <= 8'h2f) || b == 8'h3a || b == 8'h3d || b == 8'h3f ||
           b == 8'h26;
  endfunction

  function automatic bit utf8_step(input logic [7:0] b);
    logic [20:0] floor_cp;
    if (cont_left == 2'd0) begin
      if (b < 8'h80) return 1'b1;
      if (b >= 8'hc2 && b <= 8'hdf) begin
        cont_left = 2'd1;
        cp_acc = {16'd0, b[4:0]};
      end else if (b >= 8'he0 && b <= 8'hef) begin
        cont_left = 2'd2;
        cp_acc = {17'd0, b[3:0]};
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        cont_left = 2'd3;
        cp_acc = {18'd0, b[2:0]};
      end else begin
        return 1'b0;
      end
      seq_len = cont_left;
      return 1'b1;
    end
    if (b[7:6] != 2'b10) return 1'b0;
    cp_acc = {cp_acc[14:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left != 2'd0) return 1'b1;
    case (seq_len)
      2'd1:    floor_cp = CP_MIN_2BYTE;
      2'd2:    floor_cp = CP_MIN_3BYTE;
      default: floor_cp = CP_MIN_4BYTE;
    endcase
    return !(cp_acc < floor_cp || cp_acc > CP_MAX ||
             (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI));
  endfunction

  function automatic bit bmp_step(input logic [7:0] b);
    logic [15:0] unit;
    if (!half_unit) begin
      unit_hi = b;
      half_unit = 1'b1;
      return 1'b1;
    end
    half_unit = 1'b0;
    unit = {unit_hi, b};
    return !(unit >= BMP_FFFE || (unit >= BMP_NONCH_LO && unit <= BMP_NONCH_HI) ||
             (unit >= BMP_SURR_LO && unit <= BMP_SURR_HI));
  endfunction

  task automatic predict_item(input logic [7:0] tag, input logic [7:0] b,
                              input bit empty, input bit is_last);
    bit ok;
    bit verdict;
    if (!in_str) begin
      cur_kind = class_for_tag(tag);
      str_bad = (cur_kind == KIND_REJECT);
      cont_left = '0;
      seq_len = '0;
      cp_acc = '0;
      unit_hi = '0;
      half_unit = 1'b0;
    end
    if (!empty && !str_bad) begin
      case (cur_kind)
        KIND_UTF8:      ok = utf8_step(b);
        KIND_BMP:       ok = bmp_step(b);
        KIND_NUMERIC:   ok = numeric_char(b);
        KIND_PRINTABLE: ok = printable_char(b);
        KIND_IA5:       ok = !b[7];
        KIND_T61:       ok = 1'b1;
        default:        ok = 1'b0;
      endcase
      if (!ok) str_bad = 1'b1;
    end
    if (is_last) begin
      verdict = !str_bad && cont_left == 2'd0 && !half_unit;
      verdicts_due = {verdicts_due, verdict};
    end
    in_str = !is_last;
  endtask

  // ---------------------------------------------------------------------------
  // byte sender

  task automatic send_item(input logic [7:0] tag, input logic [7:0] b,
                           input bit empty, input bit is_last);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.type_tag     <= tag;
    in_ch.byte_value   <= b;
    in_ch.empty_string <= empty;
    in_ch.last         <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(tag, b, empty, is_last);
    if (!empty) bytes_sent++;
  endtask

  function automatic logic [7:0] tag_for(input logic [7:0] tag, input bit first,
                                         input bit noisy);
    return (first || !noisy) ? tag : 8'($urandom_range(0, 255));
  endfunction

  // noisy strings get stray empty transfers, junk tags after the first
  // transfer and sometimes an empty transfer that carries last
  task automatic send_string(input logic [7:0] tag, input logic [7:0] data[$],
                             input bit noisy);
    bit first;
    bit tail_empty;
    first = 1'b1;
    tail_empty = (data.size() == 0) || (noisy && $urandom_range(0, 9) == 0);
    foreach (data[i]) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        send_item(tag_for(tag, first, noisy), 8'($urandom_range(0, 255)), 1'b1, 1'b0);
        first = 1'b0;
      end
      send_item(tag_for(tag, first, noisy), data[i], 1'b0,
                !tail_empty && i == data.size() - 1);
      first = 1'b0;
    end
    if (tail_empty) send_item(tag_for(tag, first, noisy), 8'($urandom_range(0, 255)),
                              1'b1, 1'b1);
  endtask

  task automatic stop_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // random string content

  task automatic append_byte(ref logic [7:0] data[$], input logic [7:0] v);
    data = {data, v};
  endtask

  task automatic push_utf8(ref logic [7:0] data[$], input logic [20:0] cp, input int n);
    case (n)
      1: append_byte(data, {1'b0, cp[6:0]});
      2: begin
        append_byte(data, {3'b110, cp[10:6]});
        append_byte(data, {2'b10, cp[5:0]});
      end
      3: begin
        append_byte(data, {4'b1110, cp[15:12]});
        append_byte(data, {2'b10, cp[11:6]});
        append_byte(data, {2'b10, cp[5:0]});
      end
      default: begin
        append_byte(data, {5'b11110, cp[20:18]});
        append_byte(data, {2'b10, cp[17:12]});
        append_byte(data, {2'b10, cp[11:6]});
        append_byte(data, {2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic send_random_string();
    string       numeric_set;
    string       printable_set;
    logic [7:0]  data[$];
    logic [7:0]  tag;
    logic [15:0] unit;
    int          sel;
    int          chars;
    int          r;
    numeric_set = "0123456789 ";
    printable_set = "09azAZ '()*+,-./:=?&";
    sel = $urandom_range(0, 99);
    if (sel < 24)      tag = TAG_UTF8;
    else if (sel < 40) tag = TAG_BMP;
    else if (sel < 52) tag = TAG_NUMERIC;
    else if (sel < 64) tag = TAG_PRINTABLE;
    else if (sel < 76) tag = TAG_IA5;
    else if (sel < 85) tag = TAG_T61;
    else               tag = 8'($urandom_range(0, 255));
    chars = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
    repeat (chars) begin
      r = $urandom_range(0, 19);
      case (tag)
        TAG_UTF8: begin
          if (r < 8)        push_utf8(data, 21'($urandom_range(0, 'h7f)), 1);
          else if (r < 11)  push_utf8(data, 21'($urandom_range('h80, 'h7ff)), 2);
          else if (r < 13)  push_utf8(data, 21'($urandom_range('h800, 'hffff)), 3);
          else if (r == 13) push_utf8(data, 21'($urandom_range('hd7f0, 'he00f)), 3);
          else if (r == 14) push_utf8(data, 21'($urandom_range('h10000, 'h10ffff)), 4);
          else if (r == 15) push_utf8(data, 21'($urandom_range('h10fff0, 'h1fffff)), 4);
          else if (r == 16) push_utf8(data, 21'($urandom_range(0, 'h7ff)),
                                      $urandom_range(2, 4));
          else if (r == 17) append_byte(data, 8'($urandom_range(0, 255)));
          else if (r == 18) begin
            push_utf8(data, 21'($urandom_range('h800, 'hffff)), 3);
            void'(data.pop_back());
          end else begin
            append_byte(data, 8'($urandom_range('h80, 'hbf)));
          end
        end
        TAG_BMP: begin
          if (r < 12)       unit = 16'($urandom_range(0, 'hffff));
          else if (r < 14)  unit = 16'($urandom_range('hd7f0, 'he00f));
          else if (r < 16)  unit = 16'($urandom_range('hfdc8, 'hfdf7));
          else if (r < 18)  unit = 16'($urandom_range('hfff8, 'hffff));
          else              unit = 16'($urandom_range(0, 'hff));
          append_byte(data, unit[15:8]);
          append_byte(data, unit[7:0]);
          if (r == 19) void'(data.pop_back());
        end
        TAG_NUMERIC: begin
          if (r < 18) append_byte(data, numeric_set[$urandom_range(0, numeric_set.len() - 1)]);
          else        append_byte(data, 8'($urandom_range(0, 255)));
        end
        TAG_PRINTABLE: begin
          if (r < 17) append_byte(data,
                                  printable_set[$urandom_range(0, printable_set.len() - 1)]);
          else        append_byte(data, 8'($urandom_range(0, 255)));
        end
        TAG_IA5: begin
          if (r < 18) append_byte(data, 8'($urandom_range(0, 'h7f)));
          else        append_byte(data, 8'($urandom_range(0, 255)));
        end
        default: append_byte(data, 8'($urandom_range(0, 255)));
      endcase
    end
    send_string(tag, data, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_empty_strings();
    logic [7:0] none[$];
    send_string(TAG_UTF8, none, 1'b0);
    send_string(8'h00, none, 1'b0);
    send_string(8'hff, none, 1'b0);
    send_item(TAG_BMP, 8'h00, 1'b1, 1'b0);
    send_item(8'h00, 8'hff, 1'b1, 1'b1);
  endtask

  task automatic test_utf8_rules();
    send_string(TAG_UTF8, '{8'h00, 8'h7f, 8'hc2, 8'h80}, 1'b0);
    send_string(TAG_UTF8, '{8'hc1}, 1'b0);
    send_string(TAG_UTF8, '{8'hed, 8'ha0, 8'h80}, 1'b0);
    send_string(TAG_UTF8, '{8'hf4, 8'h90, 8'h80, 8'h80}, 1'b0);
    send_string(TAG_UTF8, '{8'he2, 8'h82}, 1'b0);
  endtask

  task automatic test_bmp_rules();
    send_string(TAG_BMP, '{8'hd8, 8'h00}, 1'b0);
    send_string(TAG_BMP, '{8'hff, 8'hff}, 1'b0);
    send_string(TAG_BMP, '{8'h41}, 1'b0);
  endtask

  task automatic test_char_classes();
    send_string(TAG_NUMERIC, '{8'h39, 8'h20}, 1'b0);
    send_string(TAG_PRINTABLE, '{8'h3f, 8'h21}, 1'b0);
    send_item(TAG_IA5, 8'h00, 1'b0, 1'b0);
    send_item(TAG_IA5, 8'hff, 1'b1, 1'b0);
    send_item(TAG_IA5, 8'h7f, 1'b0, 1'b1);
    send_string(TAG_IA5, '{8'h80}, 1'b0);
    send_string(TAG_T61, '{8'hff}, 1'b0);
  endtask

  // back to back transfers, then a full drain before restarting
  task automatic test_drain_pause();
    in_steady = 1'b1;
    out_steady = 1'b1;
    repeat (8) send_random_string();
    stop_input();
    wait_drained();
    in_steady = 1'b0;
    out_steady = 1'b0;
    repeat (8) send_random_string();
  endtask

  task automatic test_random_strings(input int byte_target);
    int n;
    n = 0;
    while (bytes_sent < byte_target) begin
      if (n % 20 == 0) begin
        in_steady = ($urandom_range(0, 3) == 0);
        out_steady = ($urandom_range(0, 3) == 0);
      end
      if (n % 120 == 119) begin
        stop_input();
        wait_drained();
      end
      send_random_string();
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // verdict checking

  initial begin : verdict_monitor
    int stall;
    bit want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (verdicts_due.size() == 0) begin
        report_error($sformatf("verdict %b with no string pending", out_ch.valid_res));
      end else begin
        want = verdicts_due.pop_front();
        if (out_ch.valid_res !== want)
          report_error($sformatf("valid_res %b, expected %b", out_ch.valid_res, want));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.type_tag     <= '0;
    in_ch.byte_value   <= '0;
    in_ch.empty_string <= 1'b0;
    in_ch.last         <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_strings();
    test_utf8_rules();
    test_bmp_rules();
    test_char_classes();
    test_drain_pause();
    test_random_strings(900);
    stop_input();
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
